// ===== hdl/tilt_axis_threshold_detector_assert.svh =====
// Assertion macros shared by the tilt axis threshold detector modules.
// Needs a clock clk_i and an active-low reset rst_ni in the including scope.
`ifndef TILT_AXIS_THRESHOLD_DETECTOR_ASSERT_SVH
`define TILT_AXIS_THRESHOLD_DETECTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TATD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TATD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tatd_pkg.sv =====
// Shared types and constants of the tilt axis threshold detector.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tatd_pkg;

  // Field widths.
  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned SAMPLE_MAX = 1023;
  localparam int unsigned RAW_W      = 10;
  localparam int unsigned THR_W      = 15;
  localparam int unsigned TMO_W      = 10;
  localparam int unsigned ACT_W      = 2;
  localparam int unsigned MG_W       = 16;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] REG_REST_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REST_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_THR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VERT_THR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd4;

  localparam logic [RAW_W-1:0] REST_LOW_RST  = 10'd255;
  localparam logic [RAW_W-1:0] REST_HIGH_RST = 10'd405;
  localparam logic [THR_W-1:0] SIDE_THR_RST  = 15'd300;
  localparam logic [THR_W-1:0] VERT_THR_RST  = 15'd400;
  localparam logic [TMO_W-1:0] TIMEOUT_RST   = 10'd500;

  localparam int unsigned SAMPLES_DEF = 10;

  // Mapping constants.
  localparam int MAP_SPAN = 2000;
  localparam int MAP_LOW  = -1000;
  localparam int Z_OFFSET = 1000;

  // Divider sizing: the numerator holds the largest offset times the span.
  localparam int unsigned NUM_W  = 21;
  localparam int unsigned DEN_W  = 10;
  localparam int unsigned STEP_W = $clog2(NUM_W + 1);
  // Signed scaled value before saturation.
  localparam int unsigned VAL_W  = NUM_W + 2;

  // Axis selection.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_KEEP  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POS   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_NEG   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG_START,
    ST_AVG_WAIT,
    ST_SCL_START,
    ST_SCL_WAIT,
    ST_FINISH
  } tatd_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       acc;
    logic       div_start;
    logic       div_scale;
    logic       cap_avg;
    logic       cap_val;
    logic [1:0] axis;
    logic       finish;
  } tatd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_item;
    logic div_busy;
  } tatd_sts_t;

endpackage

`default_nettype wire

// ===== hdl/tilt_axis_threshold_detector.sv =====
// Top level of the tilt axis threshold detector: configuration registers,
// controller and datapath. Depends on tatd_pkg, tatd_ctrl and tatd_dp.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one word of three raw 10-bit accelerometer readings at a time
// and sums them per axis. Every SAMPLES-th word closes a group: each sum is
// averaged with truncation, mapped linearly from the rest range [rest_low,
// rest_high] onto -1000 to +1000 milli-g (z is further lowered by 1000), and
// classified against its threshold as positive, negative or in band. In-band
// evaluations count up a per-axis rest counter; when it passes rest_timeout
// the axis reports a clear action and the counter restarts. One result word
// with three actions and three saturated 16-bit milli-g values leaves per
// group. A word that does not close a group is taken without a stall. The
// closing word stalls the input while a single restoring divider, one
// quotient bit per cycle over 21 bits, runs six divisions in turn (average
// and scaling for each axis), and until the three values are classified and
// loaded into the result register. The result register lets a finished word
// wait downstream while the next group is being summed; only a second
// finished word waits on it. Configuration is a plain write port and must
// only be written while the block is idle; an empty rest range (rest_high
// not above rest_low) forces the mapped x and y values to zero and z to
// minus 1000.
module tilt_axis_threshold_detector #(
  parameter int unsigned SAMPLES = tatd_pkg::SAMPLES_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic        [tatd_pkg::SAMPLE_W-1:0]   x_sample_i,
  input  wire logic        [tatd_pkg::SAMPLE_W-1:0]   y_sample_i,
  input  wire logic        [tatd_pkg::SAMPLE_W-1:0]   z_sample_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic             [tatd_pkg::ACT_W-1:0]      x_action_o,
  output logic             [tatd_pkg::ACT_W-1:0]      y_action_o,
  output logic             [tatd_pkg::ACT_W-1:0]      z_action_o,
  output logic signed      [tatd_pkg::MG_W-1:0]       x_milli_g_o,
  output logic signed      [tatd_pkg::MG_W-1:0]       y_milli_g_o,
  output logic signed      [tatd_pkg::MG_W-1:0]       z_milli_g_o,
  input  wire logic                                   cfg_we_i,
  input  wire logic        [tatd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic        [tatd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration registers. Writes to an unknown index are dropped, and
  // data bits above a register's width are ignored.
  logic [tatd_pkg::RAW_W-1:0] rest_low_q;
  logic [tatd_pkg::RAW_W-1:0] rest_high_q;
  logic [tatd_pkg::THR_W-1:0] side_thr_q;
  logic [tatd_pkg::THR_W-1:0] vert_thr_q;
  logic [tatd_pkg::TMO_W-1:0] timeout_q;

  tatd_pkg::tatd_cmd_t cmd;
  tatd_pkg::tatd_sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_low_q  <= tatd_pkg::REST_LOW_RST;
      rest_high_q <= tatd_pkg::REST_HIGH_RST;
      side_thr_q  <= tatd_pkg::SIDE_THR_RST;
      vert_thr_q  <= tatd_pkg::VERT_THR_RST;
      timeout_q   <= tatd_pkg::TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tatd_pkg::REG_REST_LOW:  rest_low_q  <= cfg_data_i[tatd_pkg::RAW_W-1:0];
        tatd_pkg::REG_REST_HIGH: rest_high_q <= cfg_data_i[tatd_pkg::RAW_W-1:0];
        tatd_pkg::REG_SIDE_THR:  side_thr_q  <= cfg_data_i[tatd_pkg::THR_W-1:0];
        tatd_pkg::REG_VERT_THR:  vert_thr_q  <= cfg_data_i[tatd_pkg::THR_W-1:0];
        tatd_pkg::REG_TIMEOUT:   timeout_q   <= cfg_data_i[tatd_pkg::TMO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The controller owns the handshakes and the order of the divisions.
  tatd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // The datapath holds the sums, the divider, the rest counters and the
  // result register.
  tatd_dp #(
    .SAMPLES (SAMPLES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .x_sample_i  (x_sample_i),
    .y_sample_i  (y_sample_i),
    .z_sample_i  (z_sample_i),
    .rest_low_i  (rest_low_q),
    .rest_high_i (rest_high_q),
    .side_thr_i  (side_thr_q),
    .vert_thr_i  (vert_thr_q),
    .timeout_i   (timeout_q),
    .x_action_o  (x_action_o),
    .y_action_o  (y_action_o),
    .z_action_o  (z_action_o),
    .x_milli_g_o (x_milli_g_o),
    .y_milli_g_o (y_milli_g_o),
    .z_milli_g_o (z_milli_g_o)
  );

endmodule

`default_nettype wire

// ===== hdl/tatd_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tatd_pkg for the operand widths.
`timescale 1ns / 1ps
`default_nettype none

module tatd_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [tatd_pkg::NUM_W-1:0] num_i,
  input  wire logic [tatd_pkg::DEN_W-1:0] den_i,
  output logic                            busy_o,
  output logic      [tatd_pkg::NUM_W-1:0] quo_o
);

  logic [tatd_pkg::STEP_W-1:0] step_q, step_d;
  logic [tatd_pkg::NUM_W-1:0]  quo_q, quo_d;
  logic [tatd_pkg::DEN_W-1:0]  rem_q, rem_d;
  logic [tatd_pkg::DEN_W-1:0]  den_q, den_d;
  logic [tatd_pkg::DEN_W:0]    trial;
  logic [tatd_pkg::DEN_W:0]    diff;
  logic                        fits;

  always_comb begin
    trial  = {rem_q, quo_q[tatd_pkg::NUM_W-1]};
    diff   = trial - {1'b0, den_q};
    fits   = (trial >= {1'b0, den_q});
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      step_d = tatd_pkg::STEP_W'(tatd_pkg::NUM_W);
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (step_q != '0) begin
      step_d = step_q - 1'b1;
      quo_d  = {quo_q[tatd_pkg::NUM_W-2:0], fits};
      rem_d  = fits ? diff[tatd_pkg::DEN_W-1:0] : trial[tatd_pkg::DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = (step_q != '0);
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ===== hdl/tatd_dp.sv =====
// Datapath: sample accumulators, shared divider, scaling, classification
// and the result register. Depends on tatd_pkg and tatd_div.
`timescale 1ns / 1ps
`default_nettype none

module tatd_dp #(
  parameter int unsigned SAMPLES = tatd_pkg::SAMPLES_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire tatd_pkg::tatd_cmd_t                  cmd_i,
  output tatd_pkg::tatd_sts_t                       sts_o,
  input  wire logic        [tatd_pkg::SAMPLE_W-1:0] x_sample_i,
  input  wire logic        [tatd_pkg::SAMPLE_W-1:0] y_sample_i,
  input  wire logic        [tatd_pkg::SAMPLE_W-1:0] z_sample_i,
  input  wire logic        [tatd_pkg::RAW_W-1:0]    rest_low_i,
  input  wire logic        [tatd_pkg::RAW_W-1:0]    rest_high_i,
  input  wire logic        [tatd_pkg::THR_W-1:0]    side_thr_i,
  input  wire logic        [tatd_pkg::THR_W-1:0]    vert_thr_i,
  input  wire logic        [tatd_pkg::TMO_W-1:0]    timeout_i,
  output logic             [tatd_pkg::ACT_W-1:0]    x_action_o,
  output logic             [tatd_pkg::ACT_W-1:0]    y_action_o,
  output logic             [tatd_pkg::ACT_W-1:0]    z_action_o,
  output logic signed      [tatd_pkg::MG_W-1:0]     x_milli_g_o,
  output logic signed      [tatd_pkg::MG_W-1:0]     y_milli_g_o,
  output logic signed      [tatd_pkg::MG_W-1:0]     z_milli_g_o
);

  localparam int unsigned SUM_W = $clog2(tatd_pkg::SAMPLE_MAX * SAMPLES + 1);
  localparam int unsigned CNT_W = $clog2(SAMPLES + 1);
  localparam int unsigned VAL_W = tatd_pkg::VAL_W;
  localparam int unsigned NUM_W = tatd_pkg::NUM_W;
  localparam int unsigned DEN_W = tatd_pkg::DEN_W;
  localparam int unsigned TMO_W = tatd_pkg::TMO_W;
  localparam int unsigned ACT_W = tatd_pkg::ACT_W;
  localparam int unsigned MG_W  = tatd_pkg::MG_W;

  localparam logic signed [VAL_W-1:0] SAT_HI   = VAL_W'(32767);
  localparam logic signed [VAL_W-1:0] SAT_LO   = VAL_W'(-32768);
  localparam logic signed [VAL_W-1:0] OFS_XY   = VAL_W'(tatd_pkg::MAP_LOW);
  localparam logic signed [VAL_W-1:0] OFS_Z    = VAL_W'(tatd_pkg::MAP_LOW - tatd_pkg::Z_OFFSET);
  localparam logic signed [VAL_W-1:0] EMPTY_Z  = VAL_W'(-tatd_pkg::Z_OFFSET);

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [TMO_W-1:0] count;
  } cls_t;

  function automatic cls_t classify(input logic signed [VAL_W-1:0] v,
                                    input logic [tatd_pkg::THR_W-1:0] thr,
                                    input logic [TMO_W-1:0] cnt,
                                    input logic [TMO_W-1:0] tmo);
    logic [VAL_W-1:0] mag;
    logic [TMO_W:0]   nxt;
    cls_t             r;
    mag = v[VAL_W-1] ? -v : v;
    nxt = {1'b0, cnt} + 1'b1;
    if (mag > VAL_W'(thr)) begin
      r.action = v[VAL_W-1] ? tatd_pkg::ACT_NEG : tatd_pkg::ACT_POS;
      r.count  = '0;
    end else if (nxt > {1'b0, tmo}) begin
      r.action = tatd_pkg::ACT_CLEAR;
      r.count  = '0;
    end else begin
      r.action = tatd_pkg::ACT_KEEP;
      r.count  = nxt[TMO_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [MG_W-1:0] sat16(input logic signed [VAL_W-1:0] v);
    logic [MG_W-1:0] r;
    if (v > SAT_HI) begin
      r = 16'h7FFF;
    end else if (v < SAT_LO) begin
      r = 16'h8000;
    end else begin
      r = v[MG_W-1:0];
    end
    return r;
  endfunction

  logic [SUM_W-1:0] x_sum_q, y_sum_q, z_sum_q;
  logic [CNT_W-1:0] samples_q;
  logic [tatd_pkg::RAW_W-1:0] avg_q;
  logic signed [VAL_W-1:0] val_q [3];
  logic [TMO_W-1:0] x_cnt_q, y_cnt_q, z_cnt_q;
  logic [ACT_W-1:0] x_act_q, y_act_q, z_act_q;
  logic [MG_W-1:0]  x_mg_q, y_mg_q, z_mg_q;

  logic [SUM_W-1:0]           sum_sel;
  logic                       off_neg;
  logic [tatd_pkg::RAW_W-1:0] off_mag;
  logic [NUM_W-1:0]           prod;
  logic [NUM_W-1:0]           div_num;
  logic [DEN_W-1:0]           div_den;
  logic [DEN_W-1:0]           span;
  logic                       empty;
  logic                       div_busy;
  logic [NUM_W-1:0]           div_quo;
  logic signed [VAL_W-1:0]    q_s;
  logic signed [VAL_W-1:0]    v_new;
  cls_t                       x_cls, y_cls, z_cls;

  always_comb begin
    case (cmd_i.axis)
      tatd_pkg::AXIS_X: sum_sel = x_sum_q;
      tatd_pkg::AXIS_Y: sum_sel = y_sum_q;
      default:          sum_sel = z_sum_q;
    endcase
  end

  assign empty   = (rest_high_i <= rest_low_i);
  assign span    = rest_high_i - rest_low_i;
  assign off_neg = (avg_q < rest_low_i);
  assign off_mag = off_neg ? (rest_low_i - avg_q) : (avg_q - rest_low_i);
  assign prod    = NUM_W'(off_mag) * NUM_W'(tatd_pkg::MAP_SPAN);
  assign div_num = cmd_i.div_scale ? prod : NUM_W'(sum_sel);
  assign div_den = cmd_i.div_scale ? span : DEN_W'(SAMPLES);

  tatd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  // Signed quotient plus the mapping offset; an empty rest range maps x and y to zero and z to minus 1000.
  always_comb begin
    q_s = $signed({2'b00, div_quo});
    if (off_neg) begin
      q_s = -q_s;
    end
    if (cmd_i.axis == tatd_pkg::AXIS_Z) begin
      v_new = empty ? EMPTY_Z : q_s + OFS_Z;
    end else begin
      v_new = empty ? '0 : q_s + OFS_XY;
    end
  end

  assign x_cls = classify(val_q[0], side_thr_i, x_cnt_q, timeout_i);
  assign y_cls = classify(val_q[1], side_thr_i, y_cnt_q, timeout_i);
  assign z_cls = classify(val_q[2], vert_thr_i, z_cnt_q, timeout_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_sum_q   <= '0;
      y_sum_q   <= '0;
      z_sum_q   <= '0;
      samples_q <= '0;
      x_cnt_q   <= '0;
      y_cnt_q   <= '0;
      z_cnt_q   <= '0;
    end else if (cmd_i.finish) begin
      x_sum_q   <= '0;
      y_sum_q   <= '0;
      z_sum_q   <= '0;
      samples_q <= '0;
      x_cnt_q   <= x_cls.count;
      y_cnt_q   <= y_cls.count;
      z_cnt_q   <= z_cls.count;
    end else if (cmd_i.acc) begin
      x_sum_q   <= x_sum_q + SUM_W'(x_sample_i);
      y_sum_q   <= y_sum_q + SUM_W'(y_sample_i);
      z_sum_q   <= z_sum_q + SUM_W'(z_sample_i);
      samples_q <= samples_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_avg) begin
      avg_q <= div_quo[tatd_pkg::RAW_W-1:0];
    end
    if (cmd_i.cap_val) begin
      val_q[cmd_i.axis] <= v_new;
    end
    if (cmd_i.finish) begin
      x_act_q <= x_cls.action;
      y_act_q <= y_cls.action;
      z_act_q <= z_cls.action;
      x_mg_q  <= sat16(val_q[0]);
      y_mg_q  <= sat16(val_q[1]);
      z_mg_q  <= sat16(val_q[2]);
    end
  end

  assign sts_o.last_item = (samples_q == CNT_W'(SAMPLES - 1));
  assign sts_o.div_busy  = div_busy;

  assign x_action_o  = x_act_q;
  assign y_action_o  = y_act_q;
  assign z_action_o  = z_act_q;
  assign x_milli_g_o = x_mg_q;
  assign y_milli_g_o = y_mg_q;
  assign z_milli_g_o = z_mg_q;

endmodule

`default_nettype wire

// ===== hdl/tatd_ctrl.sv =====
// Controller: sequences accumulation, the six divisions and the result hand-off.
// Depends on tatd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "tilt_axis_threshold_detector_assert.svh"

module tatd_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output tatd_pkg::tatd_cmd_t      cmd_o,
  input  wire tatd_pkg::tatd_sts_t sts_i
);

  tatd_pkg::tatd_state_e state_q, state_d;
  logic [1:0]            axis_q, axis_d;
  logic                  out_valid_q, out_valid_d;
  tatd_pkg::tatd_cmd_t   cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tatd_pkg::ST_IDLE;
      axis_q      <= tatd_pkg::AXIS_X;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    cmd     = '0;
    cmd.axis = axis_q;
    unique case (state_q)
      tatd_pkg::ST_IDLE: begin
        cmd.acc = in_valid_i;
        if (in_valid_i && sts_i.last_item) begin
          axis_d  = tatd_pkg::AXIS_X;
          state_d = tatd_pkg::ST_AVG_START;
        end
      end
      tatd_pkg::ST_AVG_START: begin
        cmd.div_start = 1'b1;
        state_d       = tatd_pkg::ST_AVG_WAIT;
      end
      tatd_pkg::ST_AVG_WAIT: begin
        if (!sts_i.div_busy) begin
          cmd.cap_avg = 1'b1;
          state_d     = tatd_pkg::ST_SCL_START;
        end
      end
      tatd_pkg::ST_SCL_START: begin
        cmd.div_start = 1'b1;
        cmd.div_scale = 1'b1;
        state_d       = tatd_pkg::ST_SCL_WAIT;
      end
      tatd_pkg::ST_SCL_WAIT: begin
        cmd.div_scale = 1'b1;
        if (!sts_i.div_busy) begin
          cmd.cap_val = 1'b1;
          if (axis_q == tatd_pkg::AXIS_Z) begin
            state_d = tatd_pkg::ST_FINISH;
          end else begin
            axis_d  = axis_q + 2'd1;
            state_d = tatd_pkg::ST_AVG_START;
          end
        end
      end
      tatd_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd.finish = 1'b1;
          state_d    = tatd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tatd_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd.finish | (out_valid_q & out_stall_i);
  assign in_stall_o  = (state_q != tatd_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  `TATD_ASSERT_NOW(a_no_overwrite, cmd.finish, !out_valid_q || !out_stall_i, "result word overwritten while stalled")
  `TATD_ASSERT_NOW(a_div_free, cmd.div_start, !sts_i.div_busy, "divider started while busy")
  `TATD_ASSERT_NEXT(a_group_start, state_q == tatd_pkg::ST_IDLE && in_valid_i && sts_i.last_item, state_q == tatd_pkg::ST_AVG_START && axis_q == tatd_pkg::AXIS_X, "group end did not start averaging")
  `TATD_ASSERT_NOW(a_axis_range, state_q != tatd_pkg::ST_IDLE, axis_q == tatd_pkg::AXIS_X || axis_q == tatd_pkg::AXIS_Y || axis_q == tatd_pkg::AXIS_Z, "axis selector out of range")

endmodule

`default_nettype wire

// ===== verif/tb_tilt_axis_threshold_detector.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the tilt axis threshold detector. It drives sample
// words and register settings, predicts every result word and checks each one.
// Depends on tatd_pkg and the tilt_axis_threshold_detector RTL only.

module tb_tilt_axis_threshold_detector;
  import tatd_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int GROUP         = SAMPLES_DEF;
  // Wait after the last result, so that any trailing work finishes before
  // registers are touched.
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES   = 1500;
  localparam int MAX_REPORTS   = 10;
  localparam int MG_MAX        = 2 ** (MG_W - 1) - 1;
  localparam int MG_MIN        = -(2 ** (MG_W - 1));
  localparam int PHASES        = 10;
  localparam int PHASE_GROUPS  = 9;

  // One result word as the block should present it.
  typedef struct {
    logic        [ACT_W-1:0] act_x;
    logic        [ACT_W-1:0] act_y;
    logic        [ACT_W-1:0] act_z;
    logic signed [MG_W-1:0]  mg_x;
    logic signed [MG_W-1:0]  mg_y;
    logic signed [MG_W-1:0]  mg_z;
  } tilt_report_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic        [SAMPLE_W-1:0]   x_sample_i;
  logic        [SAMPLE_W-1:0]   y_sample_i;
  logic        [SAMPLE_W-1:0]   z_sample_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic        [ACT_W-1:0]      x_action_o;
  logic        [ACT_W-1:0]      y_action_o;
  logic        [ACT_W-1:0]      z_action_o;
  logic signed [MG_W-1:0]       x_milli_g_o;
  logic signed [MG_W-1:0]       y_milli_g_o;
  logic signed [MG_W-1:0]       z_milli_g_o;
  logic                         cfg_we_i;
  logic        [CFG_IDX_W-1:0]  cfg_idx_i;
  logic        [CFG_DATA_W-1:0] cfg_data_i;

  // Register settings as the block should hold them.
  logic [RAW_W-1:0] rest_lo_q  = REST_LOW_RST;
  logic [RAW_W-1:0] rest_hi_q  = REST_HIGH_RST;
  logic [THR_W-1:0] side_thr_q = SIDE_THR_RST;
  logic [THR_W-1:0] vert_thr_q = VERT_THR_RST;
  logic [TMO_W-1:0] timeout_q  = TIMEOUT_RST;

  // Running sums and rest counters, as after reset.
  int               sum_x = 0;
  int               sum_y = 0;
  int               sum_z = 0;
  int               words_in_group = 0;
  logic [TMO_W-1:0] rest_cnt_x = '0;
  logic [TMO_W-1:0] rest_cnt_y = '0;
  logic [TMO_W-1:0] rest_cnt_z = '0;

  tilt_report_t expected_reports[$];

  // Idling controls, in percent per opportunity, and the long hold-off request.
  int   in_gap_pct   = 0;
  int   out_gap_pct  = 0;
  logic hold_request = 1'b0;

  int words_sent      = 0;
  int results_checked = 0;
  int clears_expected = 0;
  int settings_used   = 0;
  int mismatches      = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  tilt_axis_threshold_detector dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .x_sample_i (x_sample_i),
    .y_sample_i (y_sample_i),
    .z_sample_i (z_sample_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .x_action_o (x_action_o),
    .y_action_o (y_action_o),
    .z_action_o (z_action_o),
    .x_milli_g_o(x_milli_g_o),
    .y_milli_g_o(y_milli_g_o),
    .z_milli_g_o(z_milli_g_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Linear map of an average from the rest range onto -1000..+1000 milli-g.
  // Division truncates toward zero; an empty range maps everything to zero.
  function automatic int scale_avg(int avg);
    int span;
    span = int'(rest_hi_q) - int'(rest_lo_q);
    if (span <= 0) return 0;
    return ((avg - int'(rest_lo_q)) * MAP_SPAN) / span + MAP_LOW;
  endfunction

  // Classify one axis and advance its rest counter. The increment is taken
  // one bit wider than the counter, so a full counter still clears cleanly.
  function automatic logic [ACT_W-1:0] grade_axis(input int v, input int thr,
                                                  inout logic [TMO_W-1:0] cnt);
    int mag;
    int nxt;
    mag = (v < 0) ? -v : v;
    if (mag > thr) begin
      cnt = '0;
      return (v > 0) ? ACT_POS : ACT_NEG;
    end
    nxt = int'(cnt) + 1;
    if (nxt > int'(timeout_q)) begin
      cnt = '0;
      return ACT_CLEAR;
    end
    cnt = nxt[TMO_W-1:0];
    return ACT_KEEP;
  endfunction

  function automatic logic signed [MG_W-1:0] clamp_mg(int v);
    if (v > MG_MAX) return MG_MAX[MG_W-1:0];
    if (v < MG_MIN) return MG_MIN[MG_W-1:0];
    return v[MG_W-1:0];
  endfunction

  // Fold one accepted word into the sums; a closing word yields a result.
  task automatic absorb_word(input logic [SAMPLE_W-1:0] xs, ys, zs);
    tilt_report_t r;
    int vx;
    int vy;
    int vz;
    sum_x += xs;
    sum_y += ys;
    sum_z += zs;
    words_in_group++;
    if (words_in_group < GROUP) return;
    vx = scale_avg(sum_x / GROUP);
    vy = scale_avg(sum_y / GROUP);
    vz = scale_avg(sum_z / GROUP) - Z_OFFSET;
    words_in_group = 0;
    sum_x = 0;
    sum_y = 0;
    sum_z = 0;
    r.act_x = grade_axis(vx, int'(side_thr_q), rest_cnt_x);
    r.act_y = grade_axis(vy, int'(side_thr_q), rest_cnt_y);
    r.act_z = grade_axis(vz, int'(vert_thr_q), rest_cnt_z);
    r.mg_x  = clamp_mg(vx);
    r.mg_y  = clamp_mg(vy);
    r.mg_z  = clamp_mg(vz);
    if (r.act_x == ACT_CLEAR || r.act_y == ACT_CLEAR || r.act_z == ACT_CLEAR)
      clears_expected++;
    expected_reports.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
  endtask

  // Every accepted result word is compared with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    tilt_report_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_reports.size() == 0) begin
        note_mismatch("result word arrived with none expected");
      end else begin
        want = expected_reports.pop_front();
        results_checked++;
        if (x_action_o !== want.act_x)
          note_mismatch($sformatf("x action: expected %0d, got %0d", want.act_x, x_action_o));
        if (y_action_o !== want.act_y)
          note_mismatch($sformatf("y action: expected %0d, got %0d", want.act_y, y_action_o));
        if (z_action_o !== want.act_z)
          note_mismatch($sformatf("z action: expected %0d, got %0d", want.act_z, z_action_o));
        if (x_milli_g_o !== want.mg_x)
          note_mismatch($sformatf("x milli-g: expected %0d, got %0d", want.mg_x, x_milli_g_o));
        if (y_milli_g_o !== want.mg_y)
          note_mismatch($sformatf("y milli-g: expected %0d, got %0d", want.mg_y, y_milli_g_o));
        if (z_milli_g_o !== want.mg_z)
          note_mismatch($sformatf("z milli-g: expected %0d, got %0d", want.mg_z, z_milli_g_o));
      end
    end
  end

  // The receiving side: random stall bursts, or one long hold-off on request.
  initial begin : receiver
    int n;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (out_gap_pct != 0 && $urandom_range(0, 99) < out_gap_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one word and wait until it is taken. Valid stays high afterwards so
  // that back-to-back words need no second assignment in the same step.
  task automatic send_word(input logic [SAMPLE_W-1:0] xs, ys, zs);
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_sample_i <= xs;
    y_sample_i <= ys;
    z_sample_i <= zs;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    absorb_word(xs, ys, zs);
    words_sent++;
  endtask

  // Stop offering words and wait until every expected result has come out.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[CFG_DATA_W-1:0];
    @(posedge clk_i);
    case (idx)
      REG_REST_LOW:  rest_lo_q  = val[RAW_W-1:0];
      REG_REST_HIGH: rest_hi_q  = val[RAW_W-1:0];
      REG_SIDE_THR:  side_thr_q = val[THR_W-1:0];
      REG_VERT_THR:  vert_thr_q = val[THR_W-1:0];
      REG_TIMEOUT:   timeout_q  = val[TMO_W-1:0];
      default: ;
    endcase
  endtask

  // Writes all five registers with junk above the narrow fields, plus one
  // write to an index past the last register, which must be ignored.
  task automatic apply_settings(input int lo, hi, sthr, vthr, tmo);
    logic [CFG_IDX_W-1:0] spare_idx;
    spare_idx = REG_TIMEOUT + 1 + $urandom_range(0, 2);
    write_reg(REG_REST_LOW,  lo  + ($urandom_range(0, 31) << RAW_W));
    write_reg(REG_REST_HIGH, hi  + ($urandom_range(0, 31) << RAW_W));
    write_reg(REG_SIDE_THR,  sthr);
    write_reg(REG_VERT_THR,  vthr);
    write_reg(REG_TIMEOUT,   tmo + ($urandom_range(0, 31) << TMO_W));
    write_reg(spare_idx, $urandom_range(0, 32767));
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic apply_random_settings();
    int lo;
    int hi;
    int sthr;
    int vthr;
    int tmo;
    lo   = $urandom_range(0, 700);
    hi   = $urandom_range(lo + 1, SAMPLE_MAX);
    sthr = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 1500);
    vthr = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 1500);
    // Mostly short timeouts, so that clear actions actually happen.
    tmo  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1000) : $urandom_range(0, 6);
    apply_settings(lo, hi, sthr, vthr, tmo);
  endtask

  // Level around which a group's samples sit: near the given centre (so that
  // the axis tends to be in band), anywhere in the rest range, or anywhere.
  function automatic int pick_level(int centre);
    case ($urandom_range(0, 3))
      0, 1:    return centre - 20 + int'($urandom_range(0, 40));
      2:       return (rest_hi_q > rest_lo_q) ?
                 int'($urandom_range(rest_lo_q, rest_hi_q)) : int'($urandom_range(0, SAMPLE_MAX));
      default: return int'($urandom_range(0, SAMPLE_MAX));
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] clip_sample(int v);
    if (v < 0) return '0;
    if (v > int'(SAMPLE_MAX)) return '1;
    return v[SAMPLE_W-1:0];
  endfunction

  // One group of words with jitter around per-axis levels and the odd
  // stray word. z is centred on rest_high, where its offset brings it to zero.
  task automatic send_random_group();
    int lx;
    int ly;
    int lz;
    int jit;
    int k;
    lx  = pick_level((int'(rest_lo_q) + int'(rest_hi_q)) / 2);
    ly  = pick_level((int'(rest_lo_q) + int'(rest_hi_q)) / 2);
    lz  = pick_level(int'(rest_hi_q));
    jit = $urandom_range(0, 8);
    for (k = 0; k < GROUP; k++) begin
      if ($urandom_range(0, 19) == 0)
        send_word($urandom(), $urandom(), $urandom());
      else
        send_word(clip_sample(lx - jit + int'($urandom_range(0, 2 * jit))),
                  clip_sample(ly - jit + int'($urandom_range(0, 2 * jit))),
                  clip_sample(lz - jit + int'($urandom_range(0, 2 * jit))));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings with the sample extremes: x at full scale, y at zero and z
  // at the middle of the default rest range.
  task automatic test_reset_defaults();
    int k;
    for (k = 0; k < GROUP; k++) send_word('1, '0, 10'd330);
    drain_results();
  endtask

  // Empty rest range: every axis maps to zero, z reports minus 1000. Zero
  // timeout makes each in-band evaluation a clear at once.
  task automatic test_empty_range();
    int k;
    apply_settings(SAMPLE_MAX, 0, 0, 32767, 0);
    for (k = 0; k < GROUP; k++) send_word($urandom(), $urandom(), $urandom());
    drain_results();
  endtask

  // The receiver holds off for a long stretch while words keep coming, so
  // the result register fills, a second result waits and the input stalls.
  task automatic test_back_pressure();
    int g;
    apply_random_settings();
    in_gap_pct   = 0;
    out_gap_pct  = 0;
    hold_request = 1'b1;
    for (g = 0; g < 4; g++) send_random_group();
    drain_results();
  endtask

  // Phases of register settings, the extremes first, with random idling.
  task automatic test_random_settings();
    int p;
    int g;
    int lvl;
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_settings(0, SAMPLE_MAX, 0, 0, 1000);
        // One-count ranges give huge values that saturate both ways.
        1: apply_settings(0, 1, 32767, 32767, 0);
        2: apply_settings(SAMPLE_MAX - 1, SAMPLE_MAX, 0, 32767, 1);
        3: begin
          lvl = $urandom_range(0, SAMPLE_MAX);
          apply_settings(lvl, lvl, $urandom_range(0, 1500), $urandom_range(0, 1500),
                         $urandom_range(0, 3));
        end
        default: apply_random_settings();
      endcase
      in_gap_pct  = (p % 3 == 2) ? 0 : $urandom_range(5, 40);
      out_gap_pct = (p % 4 == 3) ? 0 : $urandom_range(5, 30);
      for (g = 0; g < PHASE_GROUPS; g++) send_random_group();
      // A few stray words shift the group boundary for the following phases.
      if ($urandom_range(0, 1) == 1)
        repeat ($urandom_range(1, GROUP - 1)) send_word($urandom(), $urandom(), $urandom());
      drain_results();
    end
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_quiet_finish();
    int g;
    apply_random_settings();
    in_gap_pct  = 0;
    out_gap_pct = 0;
    for (g = 0; g < 6; g++) send_random_group();
    drain_results();
  endtask

  initial begin : stimulus
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    x_sample_i = '0;
    y_sample_i = '0;
    z_sample_i = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_empty_range();
    test_back_pressure();
    in_gap_pct  = 20;
    out_gap_pct = 15;
    test_random_settings();
    test_quiet_finish();

    $display("Run covered %0d sample words and %0d result words under %0d register settings,",
             words_sent, results_checked, settings_used);
    $display("including %0d results with a clear action and %0d mismatches.",
             clears_expected, mismatches);
    if (mismatches == 0 && expected_reports.size() == 0)
      $display("tilt_axis_threshold_detector verification clean");
    else
      $display("tilt_axis_threshold_detector verification failed");
    $finish;
  end

  // Watchdog: many times the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("tilt_axis_threshold_detector verification failed");
    $finish;
  end

endmodule
